### hdl/homography_point_residual_assert.svh
// ----------------------------------------------------------------------------
// Homography point residual assertion macros
// Shared property forms for the residual datapath checks.
// ----------------------------------------------------------------------------
`ifndef HOMOGRAPHY_POINT_RESIDUAL_ASSERT_SVH
`define HOMOGRAPHY_POINT_RESIDUAL_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define HPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define HPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/hpr_pkg.sv
// ----------------------------------------------------------------------------
// Homography point residual package
// Widths, register indexes, limits and channel payload types.
// ----------------------------------------------------------------------------
package hpr_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int FRAC_BITS   = 8;
    localparam int COEF_W      = 32;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 3;

    // Datapath widths
    localparam int PROD_W = COEF_W + COORD_WIDTH;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MAG_W  = SUM_W - 1;
    localparam int REM_W  = MAG_W + COORD_WIDTH;
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int SQ_W   = 2 * COORD_WIDTH + 2;
    localparam int RT_W   = COORD_WIDTH + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_R1C1_R1C2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R1C3_R2C1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R2C2_R2C3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R3C1_R3C2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_R3C3      = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0]  RST_R1C1_R1C2 = 64'h0000_0001_0000_0000;
    localparam logic [CFG_W-1:0]  RST_R1C3_R2C1 = 64'h0;
    localparam logic [CFG_W-1:0]  RST_R2C2_R2C3 = 64'h0001_0000_0000_0000;
    localparam logic [CFG_W-1:0]  RST_R3C1_R3C2 = 64'h0;
    localparam logic [COEF_W-1:0] RST_R3C3      = 32'h0001_0000;

    // Saturation limits
    localparam logic [COORD_WIDTH:0] CAP_POS =
        (COORD_WIDTH+1)'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
    localparam logic [COORD_WIDTH:0] CAP_NEG =
        (COORD_WIDTH+1)'(64'd1 << (COORD_WIDTH - 1));
    localparam logic [RT_W:0] RES_MAX =
        (RT_W+1)'((64'd1 << COORD_WIDTH) - 64'd1);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] src_x;
        logic signed [COORD_WIDTH-1:0] src_y;
        logic signed [COORD_WIDTH-1:0] tgt_x;
        logic signed [COORD_WIDTH-1:0] tgt_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] proj_x;
        logic signed [COORD_WIDTH-1:0] proj_y;
        logic [COORD_WIDTH-1:0]        residual;
        logic                          saturated;
        logic                          zero_denominator;
    } out_item_t;

endpackage

### hdl/homography_point_residual.sv
// ----------------------------------------------------------------------------
// Homography point residual
// Maps a source point through a 3x3 homography and measures its distance
// to a target point.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one correspondence (source and target point,
//   signed Q.8) per transaction; m_valid/m_ready/m_data return the projected
//   point, the rounded Euclidean residual and the saturated and
//   zero_denominator flags, one result per transaction, in order.
//   Coefficients are loaded through cfg_wr_en/cfg_index/cfg_wdata while the
//   block is idle; an index above four is ignored.
//   The datapath holds a bit-per-stage quotient pipeline (COORD_WIDTH
//   stages) and a bit-per-stage square root pipeline (COORD_WIDTH+1
//   stages). Throughput is one transaction per cycle while m_ready
//   does not stall a waiting result. Reset clears all stage valid bits
//   and loads RST_*, which is not the identity: h11 resets to 32'h1.
//   When the receiver holds m_ready low with a result waiting, the whole
//   pipeline freezes and s_ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "homography_point_residual_assert.svh"

module homography_point_residual
    import hpr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    localparam int W = COORD_WIDTH;

    typedef struct packed {
        logic signed [PROD_W-1:0] p11;
        logic signed [PROD_W-1:0] p12;
        logic signed [PROD_W-1:0] p21;
        logic signed [PROD_W-1:0] p22;
        logic signed [PROD_W-1:0] p31;
        logic signed [PROD_W-1:0] p32;
        logic signed [SUM_W-1:0]  k1;
        logic signed [SUM_W-1:0]  k2;
        logic signed [SUM_W-1:0]  k3;
        logic signed [W-1:0]      tgt_x;
        logic signed [W-1:0]      tgt_y;
    } prod_t;

    typedef struct packed {
        logic [MAG_W-1:0]    mx;
        logic [MAG_W-1:0]    my;
        logic [MAG_W-1:0]    md;
        logic                nx_neg;
        logic                ny_neg;
        logic                d_neg;
        logic signed [W-1:0] tgt_x;
        logic signed [W-1:0] tgt_y;
    } sum_t;

    typedef struct packed {
        logic [REM_W-1:0]    rem_x;
        logic [REM_W-1:0]    rem_y;
        logic [W-1:0]        q_x;
        logic [W-1:0]        q_y;
        logic [MAG_W-1:0]    den;
        logic                neg_x;
        logic                neg_y;
        logic                ovf_x;
        logic                ovf_y;
        logic                zero;
        logic signed [W-1:0] tgt_x;
        logic signed [W-1:0] tgt_y;
    } div_stage_t;

    typedef struct packed {
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        logic                sat;
        logic                zero;
        logic signed [W-1:0] tgt_x;
        logic signed [W-1:0] tgt_y;
    } proj_t;

    typedef struct packed {
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        logic                sat;
        logic                zero;
        logic [DIFF_W-1:0]   dmx;
        logic [DIFF_W-1:0]   dmy;
    } diff_t;

    typedef struct packed {
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        logic                sat;
        logic                zero;
        logic [SQ_W-1:0]     sqx;
        logic [SQ_W-1:0]     sqy;
    } sq_t;

    typedef struct packed {
        logic signed [W-1:0] px;
        logic signed [W-1:0] py;
        logic                sat;
        logic                zero;
        logic [SQ_W-1:0]     rm;
        logic [RT_W-1:0]     root;
    } rt_stage_t;

    // Configuration registers
    logic [CFG_W-1:0]  coef0_reg, coef1_reg, coef2_reg, coef3_reg;
    logic [COEF_W-1:0] coef4_reg;

    // Pipeline registers and valid bits
    in_item_t   a_reg;
    prod_t      b_reg;
    sum_t       c_reg;
    div_stage_t dv_reg [0:W];
    proj_t      e_reg;
    diff_t      f_reg;
    sq_t        g_reg;
    rt_stage_t  rt_reg [0:RT_W];
    out_item_t  m_data_reg;

    logic       va_reg, vb_reg, vc_reg, ve_reg, vf_reg, vg_reg, m_valid_reg;
    logic [W:0] dv_vld_reg;
    logic [RT_W:0] rt_vld_reg;

    logic en;

    prod_t      b_next;
    sum_t       c_next;
    div_stage_t dv0_next;
    proj_t      e_next;
    diff_t      f_next;
    sq_t        g_next;
    rt_stage_t  rt0_next;
    out_item_t  m_data_next;

    logic signed [COEF_W-1:0] h11, h12, h13, h21, h22, h23, h31, h32, h33;

    // Advance the whole pipeline unless a result waits on a stalled receiver
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef0_reg <= RST_R1C1_R1C2;
            coef1_reg <= RST_R1C3_R2C1;
            coef2_reg <= RST_R2C2_R2C3;
            coef3_reg <= RST_R3C1_R3C2;
            coef4_reg <= RST_R3C3;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_R1C1_R1C2: coef0_reg <= cfg_wdata;
                REG_R1C3_R2C1: coef1_reg <= cfg_wdata;
                REG_R2C2_R2C3: coef2_reg <= cfg_wdata;
                REG_R3C1_R3C2: coef3_reg <= cfg_wdata;
                REG_R3C3:      coef4_reg <= cfg_wdata[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    assign h11 = signed'(coef0_reg[CFG_W-1:COEF_W]);
    assign h12 = signed'(coef0_reg[COEF_W-1:0]);
    assign h13 = signed'(coef1_reg[CFG_W-1:COEF_W]);
    assign h21 = signed'(coef1_reg[COEF_W-1:0]);
    assign h22 = signed'(coef2_reg[CFG_W-1:COEF_W]);
    assign h23 = signed'(coef2_reg[COEF_W-1:0]);
    assign h31 = signed'(coef3_reg[CFG_W-1:COEF_W]);
    assign h32 = signed'(coef3_reg[COEF_W-1:0]);
    assign h33 = signed'(coef4_reg);

    // Valid bits travel with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg      <= 1'b0;
            vb_reg      <= 1'b0;
            vc_reg      <= 1'b0;
            dv_vld_reg  <= '0;
            ve_reg      <= 1'b0;
            vf_reg      <= 1'b0;
            vg_reg      <= 1'b0;
            rt_vld_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            va_reg      <= s_valid;
            vb_reg      <= va_reg;
            vc_reg      <= vb_reg;
            dv_vld_reg  <= {dv_vld_reg[W-1:0], vc_reg};
            ve_reg      <= dv_vld_reg[W];
            vf_reg      <= ve_reg;
            vg_reg      <= vf_reg;
            rt_vld_reg  <= {rt_vld_reg[RT_W-1:0], vg_reg};
            m_valid_reg <= rt_vld_reg[RT_W];
        end
    end

    // Products of coefficients and source coordinates
    always_comb begin
        b_next.p11   = h11 * a_reg.src_x;
        b_next.p12   = h12 * a_reg.src_y;
        b_next.p21   = h21 * a_reg.src_x;
        b_next.p22   = h22 * a_reg.src_y;
        b_next.p31   = h31 * a_reg.src_x;
        b_next.p32   = h32 * a_reg.src_y;
        b_next.k1    = SUM_W'(h13) <<< FRAC_BITS;
        b_next.k2    = SUM_W'(h23) <<< FRAC_BITS;
        b_next.k3    = SUM_W'(h33) <<< FRAC_BITS;
        b_next.tgt_x = a_reg.tgt_x;
        b_next.tgt_y = a_reg.tgt_y;
    end

    // Sum numerators and denominator, split into sign and magnitude
    always_comb begin
        logic signed [SUM_W-1:0] nx, ny, nd;
        nx = SUM_W'(b_reg.p11) + SUM_W'(b_reg.p12) + b_reg.k1;
        ny = SUM_W'(b_reg.p21) + SUM_W'(b_reg.p22) + b_reg.k2;
        nd = SUM_W'(b_reg.p31) + SUM_W'(b_reg.p32) + b_reg.k3;
        c_next.nx_neg = nx[SUM_W-1];
        c_next.ny_neg = ny[SUM_W-1];
        c_next.d_neg  = nd[SUM_W-1];
        c_next.mx     = nx[SUM_W-1] ? MAG_W'(-nx) : MAG_W'(nx);
        c_next.my     = ny[SUM_W-1] ? MAG_W'(-ny) : MAG_W'(ny);
        c_next.md     = nd[SUM_W-1] ? MAG_W'(-nd) : MAG_W'(nd);
        c_next.tgt_x  = b_reg.tgt_x;
        c_next.tgt_y  = b_reg.tgt_y;
    end

    // Set up the divisions: overflow check, quotient signs, scaled dividends
    always_comb begin
        logic [REM_W-1:0] lim;
        lim = REM_W'(c_reg.md) << (W - FRAC_BITS);
        dv0_next.rem_x = REM_W'(c_reg.mx) << FRAC_BITS;
        dv0_next.rem_y = REM_W'(c_reg.my) << FRAC_BITS;
        dv0_next.q_x   = '0;
        dv0_next.q_y   = '0;
        dv0_next.den   = c_reg.md;
        dv0_next.neg_x = (c_reg.mx != '0) && (c_reg.nx_neg != c_reg.d_neg);
        dv0_next.neg_y = (c_reg.my != '0) && (c_reg.ny_neg != c_reg.d_neg);
        dv0_next.ovf_x = REM_W'(c_reg.mx) >= lim;
        dv0_next.ovf_y = REM_W'(c_reg.my) >= lim;
        dv0_next.zero  = (c_reg.md == '0);
        dv0_next.tgt_x = c_reg.tgt_x;
        dv0_next.tgt_y = c_reg.tgt_y;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg     <= s_data;
            b_reg     <= b_next;
            c_reg     <= c_next;
            dv_reg[0] <= dv0_next;
        end
    end

    // Restoring division, one quotient bit per stage, MSB first
    for (genvar j = 0; j < W; j++) begin : g_div
        localparam int Sh = W - 1 - j;
        div_stage_t dv_next;
        always_comb begin
            logic [REM_W-1:0] trial;
            trial   = REM_W'(dv_reg[j].den) << Sh;
            dv_next = dv_reg[j];
            if (dv_reg[j].rem_x >= trial) begin
                dv_next.rem_x    = dv_reg[j].rem_x - trial;
                dv_next.q_x[Sh]  = 1'b1;
            end
            if (dv_reg[j].rem_y >= trial) begin
                dv_next.rem_y    = dv_reg[j].rem_y - trial;
                dv_next.q_y[Sh]  = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_reg[j+1] <= dv_next;
            end
        end
    end

    // Round to nearest, ties away from zero, and saturate the projections
    always_comb begin
        logic [REM_W-1:0] half_x, half_y;
        logic [W:0]       rx, ry, cap_x, cap_y, mx, my;
        logic             sx, sy;
        half_x = REM_W'(dv_reg[W].den) - dv_reg[W].rem_x;
        half_y = REM_W'(dv_reg[W].den) - dv_reg[W].rem_y;
        rx = (W+1)'(dv_reg[W].q_x) + (W+1)'(dv_reg[W].rem_x >= half_x);
        ry = (W+1)'(dv_reg[W].q_y) + (W+1)'(dv_reg[W].rem_y >= half_y);
        cap_x = dv_reg[W].neg_x ? CAP_NEG : CAP_POS;
        cap_y = dv_reg[W].neg_y ? CAP_NEG : CAP_POS;
        sx = dv_reg[W].ovf_x || (rx > cap_x);
        sy = dv_reg[W].ovf_y || (ry > cap_y);
        mx = sx ? cap_x : rx;
        my = sy ? cap_y : ry;
        e_next.px    = dv_reg[W].neg_x ? W'(-mx) : W'(mx);
        e_next.py    = dv_reg[W].neg_y ? W'(-my) : W'(my);
        e_next.sat   = sx || sy;
        e_next.zero  = dv_reg[W].zero;
        e_next.tgt_x = dv_reg[W].tgt_x;
        e_next.tgt_y = dv_reg[W].tgt_y;
    end

    // Differences to the target, as magnitudes
    always_comb begin
        logic signed [DIFF_W-1:0] dx, dy;
        dx = DIFF_W'(e_reg.tgt_x) - DIFF_W'(e_reg.px);
        dy = DIFF_W'(e_reg.tgt_y) - DIFF_W'(e_reg.py);
        f_next.px   = e_reg.px;
        f_next.py   = e_reg.py;
        f_next.sat  = e_reg.sat;
        f_next.zero = e_reg.zero;
        f_next.dmx  = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        f_next.dmy  = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
    end

    // Squares
    always_comb begin
        g_next.px   = f_reg.px;
        g_next.py   = f_reg.py;
        g_next.sat  = f_reg.sat;
        g_next.zero = f_reg.zero;
        g_next.sqx  = SQ_W'(f_reg.dmx) * SQ_W'(f_reg.dmx);
        g_next.sqy  = SQ_W'(f_reg.dmy) * SQ_W'(f_reg.dmy);
    end

    // Sum of squares seeds the root
    always_comb begin
        rt0_next.px   = g_reg.px;
        rt0_next.py   = g_reg.py;
        rt0_next.sat  = g_reg.sat;
        rt0_next.zero = g_reg.zero;
        rt0_next.rm   = g_reg.sqx + g_reg.sqy;
        rt0_next.root = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg     <= e_next;
            f_reg     <= f_next;
            g_reg     <= g_next;
            rt_reg[0] <= rt0_next;
        end
    end

    // Digit-by-digit square root, one root bit per stage, MSB first
    for (genvar j = 0; j < RT_W; j++) begin : g_rt
        localparam int Sh = RT_W - 1 - j;
        rt_stage_t rt_next;
        always_comb begin
            logic [SQ_W+1:0] inc;
            inc = ((SQ_W+2)'(rt_reg[j].root) << (Sh + 1))
                + ((SQ_W+2)'(1) << (2 * Sh));
            rt_next = rt_reg[j];
            if ((SQ_W+2)'(rt_reg[j].rm) >= inc) begin
                rt_next.rm       = rt_reg[j].rm - SQ_W'(inc);
                rt_next.root[Sh] = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rt_reg[j+1] <= rt_next;
            end
        end
    end

    // Round the root, saturate, and zero all other fields on a zero denominator
    always_comb begin
        logic [RT_W:0] r;
        logic          sr;
        r  = (RT_W+1)'(rt_reg[RT_W].root)
           + (RT_W+1)'((SQ_W+1)'(rt_reg[RT_W].rm) > (SQ_W+1)'(rt_reg[RT_W].root));
        sr = r > RES_MAX;
        if (rt_reg[RT_W].zero) begin
            m_data_next = '0;
            m_data_next.zero_denominator = 1'b1;
        end else begin
            m_data_next.proj_x           = rt_reg[RT_W].px;
            m_data_next.proj_y           = rt_reg[RT_W].py;
            m_data_next.residual         = sr ? W'(RES_MAX) : W'(r);
            m_data_next.saturated        = rt_reg[RT_W].sat || sr;
            m_data_next.zero_denominator = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    // Checks
    `HPR_ASSERT_NOW(a_zero_den_clears, m_valid_reg && m_data_reg.zero_denominator, m_data_reg.proj_x == '0 && m_data_reg.proj_y == '0 && m_data_reg.residual == '0 && !m_data_reg.saturated, "zero denominator result carries nonzero fields")
    `HPR_ASSERT_NEXT(a_stall_freezes, !s_ready, $stable(dv_vld_reg) && $stable(rt_vld_reg), "pipeline moved during a stall")
    `HPR_ASSERT_NOW(a_result_from_root, $rose(m_valid_reg), $past(rt_vld_reg[RT_W]), "result appeared without a finished root stage")

endmodule
